@@ design/mf3x3_pkg.sv @@
`default_nettype none

package mf3x3_pkg;

  // Line store depth and the column counter width that follows from it.
  localparam int MAX_WIDTH = 256;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  localparam int PIX_W   = 8;
  localparam int IMG_W_W = 9;
  localparam int IMG_H_W = 16;
  localparam int WIN_N   = 9;
  localparam int MIN_DIM = 3;

  // Wide enough for the used width, the used width plus one and the pending count.
  localparam int CMP_W = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register index, taken from paddr[2].
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 9'd256;
  localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 16'd256;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

  typedef enum logic [1:0] {
    SEL_MEDIAN,
    SEL_UPPER,
    SEL_MID_NEW,
    SEL_MIDDLE
  } val_sel_e;

  typedef struct packed {
    logic     pixel;
    logic     emit;
    logic     last;
    val_sel_e sel;
  } s1_ctrl_t;

  // Nineteen compare-exchange steps; entry 4 ends up holding the median.
  function automatic pix_t median9(input win_t w);
    pix_t v [WIN_N];
    pix_t t;
    for (int i = 0; i < WIN_N; i++) begin
      v[i] = w[i];
    end
    if (v[1] > v[2]) begin t = v[1]; v[1] = v[2]; v[2] = t; end
    if (v[4] > v[5]) begin t = v[4]; v[4] = v[5]; v[5] = t; end
    if (v[7] > v[8]) begin t = v[7]; v[7] = v[8]; v[8] = t; end
    if (v[0] > v[1]) begin t = v[0]; v[0] = v[1]; v[1] = t; end
    if (v[3] > v[4]) begin t = v[3]; v[3] = v[4]; v[4] = t; end
    if (v[6] > v[7]) begin t = v[6]; v[6] = v[7]; v[7] = t; end
    if (v[1] > v[2]) begin t = v[1]; v[1] = v[2]; v[2] = t; end
    if (v[4] > v[5]) begin t = v[4]; v[4] = v[5]; v[5] = t; end
    if (v[7] > v[8]) begin t = v[7]; v[7] = v[8]; v[8] = t; end
    if (v[0] > v[3]) begin t = v[0]; v[0] = v[3]; v[3] = t; end
    if (v[5] > v[8]) begin t = v[5]; v[5] = v[8]; v[8] = t; end
    if (v[4] > v[7]) begin t = v[4]; v[4] = v[7]; v[7] = t; end
    if (v[3] > v[6]) begin t = v[3]; v[3] = v[6]; v[6] = t; end
    if (v[1] > v[4]) begin t = v[1]; v[1] = v[4]; v[4] = t; end
    if (v[2] > v[5]) begin t = v[2]; v[2] = v[5]; v[5] = t; end
    if (v[4] > v[7]) begin t = v[4]; v[4] = v[7]; v[7] = t; end
    if (v[4] > v[2]) begin t = v[4]; v[4] = v[2]; v[2] = t; end
    if (v[6] > v[4]) begin t = v[6]; v[6] = v[4]; v[4] = t; end
    if (v[4] > v[2]) begin t = v[4]; v[4] = v[2]; v[2] = t; end
    return v[4];
  endfunction

endpackage

`default_nettype wire

@@ design/median_filter_3x3_unit.sv @@
// An accepted request is held in the second stage; a result then moves to the output register.
// Throughput: one request per clock, pixel or flush; the line store read and write port pair
// and the commit stage set that figure, and output stall back-pressures the input.
// Reset (rst_ni low, asynchronous): counters, the 3x3 window and the pipeline valids clear,
// and the image size returns to 256 x 256. The line stores are not cleared: each entry is
// written by the first image row before any output depends on it.
`default_nettype none

module median_filter_3x3_unit
  import mf3x3_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,

  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              opcode_i,
  input  wire logic [PIX_W-1:0]  pixel_in_i,

  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [PIX_W-1:0]  pixel_out_o,
  output logic                   frame_last_o,

  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers. The register index is paddr[2]; the low address
  // bits select a byte lane and are not decoded.
  // ---------------------------------------------------------------------------
  logic [IMG_W_W-1:0] img_w_q;
  logic [IMG_H_W-1:0] img_h_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= IMAGE_WIDTH_RST;
      img_h_q <= IMAGE_HEIGHT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_IMAGE_WIDTH) begin
        img_w_q <= pwdata[IMG_W_W-1:0];
      end else begin
        img_h_q <= pwdata[IMG_H_W-1:0];
      end
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = APB_DW'(img_w_q);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(img_h_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Used image size. The width is held to 3..MAX_WIDTH and the height to at
  // least 3; a full pipeline holds one row plus one pixel of pending inputs.
  // ---------------------------------------------------------------------------
  logic [CMP_W-1:0]   w_raw;
  logic [CMP_W-1:0]   w_use;
  logic [CMP_W-1:0]   full;
  logic [IMG_H_W-1:0] h_use;

  always_comb begin
    w_raw = CMP_W'(img_w_q);
    if (w_raw < CMP_W'(MIN_DIM)) begin
      w_use = CMP_W'(MIN_DIM);
    end else if (w_raw > CMP_W'(MAX_WIDTH)) begin
      w_use = CMP_W'(MAX_WIDTH);
    end else begin
      w_use = w_raw;
    end
    h_use = (img_h_q < IMG_H_W'(MIN_DIM)) ? IMG_H_W'(MIN_DIM) : img_h_q;
    full  = w_use + CMP_W'(1);
  end

  // ---------------------------------------------------------------------------
  // Position counters. They advance when a request is accepted, so the read
  // addresses for the next request are ready at once. A position left at or
  // above a limit by a size change counts as zero; pending is held to full.
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0]   in_col_q,  in_col_d,  in_col_e;
  logic [IMG_H_W-1:0] in_row_q,  in_row_d,  in_row_e;
  logic [COL_W-1:0]   out_col_q, out_col_d, out_col_e;
  logic [IMG_H_W-1:0] out_row_q, out_row_d, out_row_e;
  logic [CMP_W-1:0]   pend_q,    pend_d,    pend_e;

  logic [CMP_W-1:0]   in_col_inc, out_col_inc;
  logic [IMG_H_W-1:0] in_row_inc, out_row_inc;
  logic               is_flush, pend_full, interior, at_last;
  s1_ctrl_t           ctrl_d;
  logic               accept;

  always_comb begin
    in_col_e  = (CMP_W'(in_col_q) >= w_use)  ? '0 : in_col_q;
    out_col_e = (CMP_W'(out_col_q) >= w_use) ? '0 : out_col_q;
    in_row_e  = (in_row_q >= h_use)  ? '0 : in_row_q;
    out_row_e = (out_row_q >= h_use) ? '0 : out_row_q;
    pend_e    = (pend_q > full) ? full : pend_q;

    in_col_inc  = CMP_W'(in_col_e) + CMP_W'(1);
    out_col_inc = CMP_W'(out_col_e) + CMP_W'(1);
    in_row_inc  = in_row_e + IMG_H_W'(1);
    out_row_inc = out_row_e + IMG_H_W'(1);

    is_flush  = (opcode_i == OP_FLUSH);
    pend_full = (pend_e == full);
    interior  = (out_row_e != '0) && (out_row_e <= h_use - IMG_H_W'(2)) &&
                (out_col_e != '0) && (CMP_W'(out_col_e) <= w_use - CMP_W'(2));
    at_last   = (out_row_e == h_use - IMG_H_W'(1)) &&
                (CMP_W'(out_col_e) == w_use - CMP_W'(1));

    ctrl_d.pixel = !is_flush;
    ctrl_d.emit  = 1'b0;
    ctrl_d.last  = 1'b0;
    ctrl_d.sel   = SEL_UPPER;
    pend_d       = pend_e;
    in_col_d     = in_col_e;
    in_row_d     = in_row_e;
    out_col_d    = out_col_e;
    out_row_d    = out_row_e;

    if (!is_flush) begin
      if (in_col_inc >= w_use) begin
        in_col_d = '0;
        in_row_d = (in_row_inc >= h_use) ? '0 : in_row_inc;
      end else begin
        in_col_d = in_col_inc[COL_W-1:0];
      end
    end

    // A flush drains one pending output as a plain pass-through. While the
    // pipeline is full that pixel sits in the upper store, after the first
    // flush it sits in the middle store. A pixel yields a result only once
    // the pipeline is full; an interior position takes the window median,
    // a border position passes the centre pixel from the upper store at the
    // output column, or from the middle store when both columns are equal.
    if (is_flush) begin
      if (pend_e != '0) begin
        ctrl_d.emit = 1'b1;
        ctrl_d.sel  = pend_full ? SEL_UPPER : SEL_MIDDLE;
        pend_d      = pend_e - CMP_W'(1);
      end
    end else if (!pend_full) begin
      pend_d = pend_e + CMP_W'(1);
    end else begin
      ctrl_d.emit = 1'b1;
      if (interior) begin
        ctrl_d.sel = SEL_MEDIAN;
      end else if (out_col_e == in_col_e) begin
        ctrl_d.sel = SEL_MID_NEW;
      end else begin
        ctrl_d.sel = SEL_UPPER;
      end
    end

    if (ctrl_d.emit) begin
      ctrl_d.last = at_last;
      if (out_col_inc >= w_use) begin
        out_col_d = '0;
        out_row_d = (out_row_inc >= h_use) ? '0 : out_row_inc;
      end else begin
        out_col_d = out_col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pend_q    <= '0;
    end else if (accept) begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      pend_q    <= pend_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores. Port A reads at the input column, port B at the output
  // column. Writes land when a pixel request commits from the second stage,
  // which can be the same edge at which the next request reads, so the stores
  // forward write data to a read of the same address.
  // ---------------------------------------------------------------------------
  logic             s1_valid_q;
  s1_ctrl_t         s1_ctrl_q;
  pix_t             s1_pix_q;
  logic [COL_W-1:0] s1_waddr_q;
  logic             s1_go;
  logic             st_we;
  pix_t             up_a_rd, up_b_rd, mid_a_rd, mid_b_rd;

  assign st_we = s1_go && s1_ctrl_q.pixel;

  mf3x3_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_upper (
    .clk_i     (clk_i),
    .we_i      (st_we),
    .waddr_i   (s1_waddr_q),
    .wdata_i   (mid_a_rd),
    .re_i      (accept),
    .raddr_a_i (in_col_e),
    .raddr_b_i (out_col_e),
    .rdata_a_o (up_a_rd),
    .rdata_b_o (up_b_rd)
  );

  mf3x3_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_middle (
    .clk_i     (clk_i),
    .we_i      (st_we),
    .waddr_i   (s1_waddr_q),
    .wdata_i   (s1_pix_q),
    .re_i      (accept),
    .raddr_a_i (in_col_e),
    .raddr_b_i (out_col_e),
    .rdata_a_o (mid_a_rd),
    .rdata_b_o (mid_b_rd)
  );

  // ---------------------------------------------------------------------------
  // Second stage: shifts the window on a pixel, picks the result and commits.
  // A request without a result always commits; one with a result waits for
  // room in the output register.
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  pix_t pixel_out_q;
  logic frame_last_q;
  win_t win_q;
  win_t win_new;
  pix_t val;
  logic out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_go      = s1_valid_q && (!s1_ctrl_q.emit || out_free);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    // Each window row drops its oldest pixel and takes the newest column.
    win_new    = win_q;
    win_new[0] = win_q[1];
    win_new[1] = win_q[2];
    win_new[2] = up_a_rd;
    win_new[3] = win_q[4];
    win_new[4] = win_q[5];
    win_new[5] = mid_a_rd;
    win_new[6] = win_q[7];
    win_new[7] = win_q[8];
    win_new[8] = s1_pix_q;

    case (s1_ctrl_q.sel)
      SEL_MEDIAN:  val = median9(win_new);
      SEL_UPPER:   val = up_b_rd;
      SEL_MID_NEW: val = mid_a_rd;
      SEL_MIDDLE:  val = mid_b_rd;
      default:     val = up_b_rd;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctrl_q  <= ctrl_d;
      s1_pix_q   <= pixel_in_i;
      s1_waddr_q <= in_col_e;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (st_we) begin
      win_q <= win_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_ctrl_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_ctrl_q.emit) begin
      pixel_out_q  <= val;
      frame_last_q <= s1_ctrl_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pixel_out_q;
  assign frame_last_o = frame_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // The pending count never passes one row plus one pixel of the largest image.
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= CMP_W'(MAX_WIDTH) + CMP_W'(1))
    else $error("pending count out of range");

  // The last pixel of a frame sends the output position back to the origin.
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && ctrl_d.emit && ctrl_d.last |=> (out_col_q == '0) && (out_row_q == '0))
    else $error("output position did not wrap after the last pixel");

  // A flush that produces a result removes exactly one pending input.
  a_flush_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_flush && ctrl_d.emit |=> pend_q == $past(pend_e) - CMP_W'(1))
    else $error("flush did not drain one pending input");
`endif

endmodule

`default_nettype wire

@@ design/mf3x3_ram.sv @@
`default_nettype none

module mf3x3_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_a_i,
  input  wire logic [AW-1:0]     raddr_b_i,
  output logic      [DATA_W-1:0] rdata_a_o,
  output logic      [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_a_q;
  logic [DATA_W-1:0] rdata_b_q;

  // A read of the address being written returns the new data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= (we_i && (waddr_i == raddr_a_i)) ? wdata_i : mem_q[raddr_a_i];
      rdata_b_q <= (we_i && (waddr_i == raddr_b_i)) ? wdata_i : mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire
